>>> rtl/dsu_pkg.sv
// Shared types, widths and the microcode store of the disjoint-set engine.
`default_nettype none

package dsu_pkg;

   // Fixed field widths of the request and response channels.
   localparam int EL_W = 10;   // element index fields
   localparam int SZ_OUT_W = 11;  // size and count fields

   // Request mode codes.
   localparam logic MODE_FIND  = 1'b0;
   localparam logic MODE_MERGE = 1'b1;

   // Sequencer steps; the step counter holds one of these.
   typedef enum logic [3:0] {
      S_CLR,    // clearing pass after reset
      S_IDLE,   // wait for a request
      S_RANGE,  // range check, first parent read
      S_WALK,   // climb one level per cycle
      S_CRD,    // compression: read parent of walker
      S_CWR,    // compression: point walker at root
      S_FDONE,  // latch root, maybe start second find
      S_SZA,    // read size of first root
      S_SZB,    // read size of second root
      S_LINK,   // hang smaller root under larger
      S_SZCAP,  // capture size of reported root
      S_EMIT    // hand the result to the output register
   } step_type;

   // Datapath operation selected by a control word.
   typedef enum logic [3:0] {
      OP_CLR,
      OP_IDLE,
      OP_FRD,
      OP_WALK,
      OP_CRD,
      OP_CWR,
      OP_FDONE,
      OP_SZA,
      OP_SZB,
      OP_LINK,
      OP_SZCAP,
      OP_EMIT
   } op_type;

   // Branch conditions tested by the sequencer.
   typedef enum logic [3:0] {
      C_ALWAYS,
      C_CLR_LAST,
      C_REQ,
      C_BAD,
      C_IS_ROOT,
      C_AT_TOP,
      C_NEED_B,
      C_UNITE,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type t_true;
      step_type t_false;
   } ucode_type;

   // Microcode store: one control word per step.
   function automatic ucode_type ucode(input step_type s);
      ucode_type w;
      unique case (s)
         S_CLR:   w = '{OP_CLR,   C_CLR_LAST, S_IDLE,  S_CLR};
         S_IDLE:  w = '{OP_IDLE,  C_REQ,      S_RANGE, S_IDLE};
         S_RANGE: w = '{OP_FRD,   C_BAD,      S_EMIT,  S_WALK};
         S_WALK:  w = '{OP_WALK,  C_IS_ROOT,  S_CRD,   S_WALK};
         S_CRD:   w = '{OP_CRD,   C_AT_TOP,   S_FDONE, S_CWR};
         S_CWR:   w = '{OP_CWR,   C_ALWAYS,   S_CRD,   S_CRD};
         S_FDONE: w = '{OP_FDONE, C_NEED_B,   S_WALK,  S_SZA};
         S_SZA:   w = '{OP_SZA,   C_UNITE,    S_SZB,   S_SZCAP};
         S_SZB:   w = '{OP_SZB,   C_ALWAYS,   S_LINK,  S_LINK};
         S_LINK:  w = '{OP_LINK,  C_ALWAYS,   S_EMIT,  S_EMIT};
         S_SZCAP: w = '{OP_SZCAP, C_ALWAYS,   S_EMIT,  S_EMIT};
         S_EMIT:  w = '{OP_EMIT,  C_OUT_FREE, S_IDLE,  S_EMIT};
         default: w = '{OP_IDLE,  C_REQ,      S_RANGE, S_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/disjoint_set_union_engine_core.sv
// Union-find engine top level: microcoded sequencer, parent and size memories.
`default_nettype none

// Disjoint-set table over ELEMENTS entries with union by size and full path
// compression. A request (req_) is a find (mode 0) or a merge (mode 1); each
// gives exactly one response (rsp_) with the root, the already-joined flag,
// the size of the root's set and the number of sets left. An element index
// not below ELEMENTS makes the request a no-op that reports root_set_size 0.
// After reset a clearing pass writes every entry to its own set; req_ready
// stays low during it. The parent memory has one registered read port, so
// the walk reads one tree level at a time, and compression reads and then
// writes each node on the path. The emit step stalls while an earlier result
// still waits in the output register. Union by size keeps tree depth at or
// below log2(ELEMENTS). One request is in flight at a time; req_ready rises
// at the edge that loads the result, so the next transfer can come while
// that result still sits in the output register.
module disjoint_set_union_engine_core #(
   parameter int ELEMENTS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_mode,
   input  wire logic [dsu_pkg::EL_W-1:0]      req_first_element,
   input  wire logic [dsu_pkg::EL_W-1:0]      req_second_element,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [dsu_pkg::EL_W-1:0]           rsp_root,
   output logic                               rsp_already_joined,
   output logic [dsu_pkg::SZ_OUT_W-1:0]       rsp_root_set_size,
   output logic [dsu_pkg::SZ_OUT_W-1:0]       rsp_component_count
);

   localparam int IDX_W = $clog2(ELEMENTS);
   localparam int SZ_W  = $clog2(ELEMENTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENTS - 1);

   // storage
   logic [IDX_W-1:0] par_mem  [ELEMENTS];
   logic [SZ_W-1:0]  size_mem [ELEMENTS];

   // sequencer
   dsu_pkg::step_type  step_ff, step_in;
   dsu_pkg::ucode_type uw;
   logic               cond_hit;

   // datapath registers
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] cur_ff, cur_in;      // find walker
   logic [IDX_W-1:0] start_ff, start_in;  // element the find began at
   logic [IDX_W-1:0] walk_ff, walk_in;    // compression walker
   logic [IDX_W-1:0] top_ff, top_in;      // root found by the walk
   logic [IDX_W-1:0] ra_ff, ra_in;
   logic [IDX_W-1:0] rb_ff, rb_in;
   logic [IDX_W-1:0] b_ff, b_in;
   logic             mode_ff, mode_in;    // merge request
   logic             bad_ff, bad_in;
   logic             sel_ff, sel_in;      // second find of a merge
   logic [SZ_W-1:0]  sa_ff, sa_in;
   logic [dsu_pkg::EL_W-1:0] res_root_ff, res_root_in;
   logic             joined_ff, joined_in;
   logic [SZ_W-1:0]  res_size_ff, res_size_in;
   logic [SZ_W-1:0]  cnt_ff, cnt_in;

   // memory read data
   logic [IDX_W-1:0] par_q_ff;
   logic [SZ_W-1:0]  size_q_ff;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dsu_pkg::EL_W-1:0]     rsp_root_ff, rsp_root_in;
   logic                         rsp_joined_ff, rsp_joined_in;
   logic [dsu_pkg::SZ_OUT_W-1:0] rsp_size_ff, rsp_size_in;
   logic [dsu_pkg::SZ_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   // memory port controls
   logic             par_re, par_we, size_re, size_we;
   logic [IDX_W-1:0] par_ra, par_wa, par_wd, size_ra, size_wa;
   logic [SZ_W-1:0]  size_wd, size_sum;
   logic             out_free;

   assign uw       = dsu_pkg::ucode(step_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign size_sum = sa_ff + size_q_ff;

   // ---------------- next step ----------------
   always_comb begin
      unique case (uw.cond)
         dsu_pkg::C_ALWAYS:   cond_hit = 1'b1;
         dsu_pkg::C_CLR_LAST: cond_hit = (clr_ff == LAST_IDX);
         dsu_pkg::C_REQ:      cond_hit = req_valid;
         dsu_pkg::C_BAD:      cond_hit = bad_ff;
         dsu_pkg::C_IS_ROOT:  cond_hit = (par_q_ff == cur_ff);
         dsu_pkg::C_AT_TOP:   cond_hit = (walk_ff == top_ff);
         dsu_pkg::C_NEED_B:   cond_hit = mode_ff && !sel_ff;
         dsu_pkg::C_UNITE:    cond_hit = mode_ff && (ra_ff != rb_ff);
         dsu_pkg::C_OUT_FREE: cond_hit = out_free;
         default:             cond_hit = 1'b0;
      endcase
      step_in = cond_hit ? uw.t_true : uw.t_false;
   end

   // ---------------- datapath control ----------------
   always_comb begin
      clr_in      = clr_ff;
      cur_in      = cur_ff;
      start_in    = start_ff;
      walk_in     = walk_ff;
      top_in      = top_ff;
      ra_in       = ra_ff;
      rb_in       = rb_ff;
      b_in        = b_ff;
      mode_in     = mode_ff;
      bad_in      = bad_ff;
      sel_in      = sel_ff;
      sa_in       = sa_ff;
      res_root_in = res_root_ff;
      joined_in   = joined_ff;
      res_size_in = res_size_ff;
      cnt_in      = cnt_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_joined_in = rsp_joined_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready   = 1'b0;
      par_re      = 1'b0;
      par_ra      = cur_ff;
      par_we      = 1'b0;
      par_wa      = walk_ff;
      par_wd      = top_ff;
      size_re     = 1'b0;
      size_ra     = ra_ff;
      size_we     = 1'b0;
      size_wa     = ra_ff;
      size_wd     = size_sum;

      unique case (uw.op)
         dsu_pkg::OP_CLR: begin
            par_we  = 1'b1;
            par_wa  = clr_ff;
            par_wd  = clr_ff;
            size_we = 1'b1;
            size_wa = clr_ff;
            size_wd = SZ_W'(1);
            clr_in  = clr_ff + IDX_W'(1);
         end
         dsu_pkg::OP_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in     = (req_mode == dsu_pkg::MODE_MERGE);
               cur_in      = IDX_W'(req_first_element);
               start_in    = IDX_W'(req_first_element);
               b_in        = IDX_W'(req_second_element);
               bad_in      = (32'(req_first_element) >= ELEMENTS)
                             || ((req_mode == dsu_pkg::MODE_MERGE)
                                 && (32'(req_second_element) >= ELEMENTS));
               sel_in      = 1'b0;
               res_root_in = req_first_element;
               joined_in   = 1'b0;
               res_size_in = '0;
            end
         end
         dsu_pkg::OP_FRD: begin
            par_re = 1'b1;
            par_ra = cur_ff;
         end
         dsu_pkg::OP_WALK: begin
            if (par_q_ff != cur_ff) begin
               cur_in = par_q_ff;
               par_re = 1'b1;
               par_ra = par_q_ff;
            end else begin
               top_in  = cur_ff;
               walk_in = start_ff;
            end
         end
         dsu_pkg::OP_CRD: begin
            par_re = 1'b1;
            par_ra = walk_ff;
         end
         dsu_pkg::OP_CWR: begin
            par_we  = 1'b1;
            par_wa  = walk_ff;
            par_wd  = top_ff;
            walk_in = par_q_ff;
         end
         dsu_pkg::OP_FDONE: begin
            if (!sel_ff) begin
               ra_in = top_ff;
            end else begin
               rb_in = top_ff;
            end
            if (mode_ff && !sel_ff) begin
               sel_in   = 1'b1;
               cur_in   = b_ff;
               start_in = b_ff;
               par_re   = 1'b1;
               par_ra   = b_ff;
            end
         end
         dsu_pkg::OP_SZA: begin
            size_re     = 1'b1;
            size_ra     = ra_ff;
            res_root_in = dsu_pkg::EL_W'(ra_ff);
            joined_in   = mode_ff && (ra_ff == rb_ff);
         end
         dsu_pkg::OP_SZB: begin
            sa_in   = size_q_ff;
            size_re = 1'b1;
            size_ra = rb_ff;
         end
         dsu_pkg::OP_LINK: begin
            par_we      = 1'b1;
            size_we     = 1'b1;
            size_wd     = size_sum;
            res_size_in = size_sum;
            cnt_in      = cnt_ff - SZ_W'(1);
            if (sa_ff < size_q_ff) begin
               par_wa      = ra_ff;
               par_wd      = rb_ff;
               size_wa     = rb_ff;
               res_root_in = dsu_pkg::EL_W'(rb_ff);
            end else begin
               par_wa      = rb_ff;
               par_wd      = ra_ff;
               size_wa     = ra_ff;
               res_root_in = dsu_pkg::EL_W'(ra_ff);
            end
         end
         dsu_pkg::OP_SZCAP: begin
            res_size_in = size_q_ff;
         end
         dsu_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_root_in   = res_root_ff;
               rsp_joined_in = joined_ff;
               rsp_size_in   = dsu_pkg::SZ_OUT_W'(res_size_ff);
               rsp_cnt_in    = dsu_pkg::SZ_OUT_W'(cnt_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[par_wa] <= par_wd;
      end
      if (par_re) begin
         par_q_ff <= par_mem[par_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[size_wa] <= size_wd;
      end
      if (size_re) begin
         size_q_ff <= size_mem[size_ra];
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= dsu_pkg::S_CLR;
         clr_ff       <= '0;
         cnt_ff       <= SZ_W'(ELEMENTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      start_ff      <= start_in;
      walk_ff       <= walk_in;
      top_ff        <= top_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      b_ff          <= b_in;
      mode_ff       <= mode_in;
      bad_ff        <= bad_in;
      sel_ff        <= sel_in;
      sa_ff         <= sa_in;
      res_root_ff   <= res_root_in;
      joined_ff     <= joined_in;
      res_size_ff   <= res_size_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_joined_ff <= rsp_joined_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_root            = rsp_root_ff;
   assign rsp_already_joined  = rsp_joined_ff;
   assign rsp_root_set_size   = rsp_size_ff;
   assign rsp_component_count = rsp_cnt_ff;

`ifndef SYNTHESIS
   // a new result only comes out of the emit step
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff) == dsu_pkg::S_EMIT)
      else $error("result appeared outside emit step");

   // linking two equal roots would corrupt the forest
   a_link_distinct: assert property (@(posedge clock) disable iff (reset)
      (step_ff == dsu_pkg::S_LINK) |-> (ra_ff != rb_ff))
      else $error("link of identical roots");

   // set count only moves on a link
   a_cnt_link: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (cnt_ff != $past(cnt_ff))) |-> $past(step_ff) == dsu_pkg::S_LINK)
      else $error("set count changed outside link");

   // at least one set always remains
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0)
      else $error("set count reached zero");
`endif

endmodule

`default_nettype wire

>>> test/tb_disjoint_set_union_engine_core.sv
// Self-checking testbench for the union-find engine core.
`timescale 1ns / 100ps

// The bench drives find and merge requests into the engine. It keeps its own
// union-find table, with union by size and full path compression, and uses it
// to compute the expected response of every accepted request. Responses are
// checked in order, field by field, against a queue of predicted outcomes.
//
// Notes taken from the core's header:
//   - after reset a clearing pass keeps req_ready low
//   - depth stays at or below log2(ELEMENTS)
//
// Inputs change on the falling edge; everything is sampled on the rising edge.
module tb_disjoint_set_union_engine_core;
   localparam int EL_W = dsu_pkg::EL_W;
   localparam int SZ_OUT_W = dsu_pkg::SZ_OUT_W;

   localparam int N_ELEMENTS = 1024;
   localparam logic MODE_FIND = dsu_pkg::MODE_FIND;
   localparam logic MODE_MERGE = dsu_pkg::MODE_MERGE;
   localparam int IDLE_PCT = 37;       // chance per cycle that a side idles
   localparam int DRAIN_CYCLES = 80;   // longest request, rounded up

   typedef struct packed {
      logic [EL_W-1:0]     root;
      logic                joined;
      logic [SZ_OUT_W-1:0] set_size;
      logic [SZ_OUT_W-1:0] count;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_mode = MODE_FIND;
   logic [EL_W-1:0]     req_first_element = '0;
   logic [EL_W-1:0]     req_second_element = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [EL_W-1:0]     rsp_root;
   logic                rsp_already_joined;
   logic [SZ_OUT_W-1:0] rsp_root_set_size;
   logic [SZ_OUT_W-1:0] rsp_component_count;

   // Shadow union-find table.
   logic [EL_W-1:0] parent_tbl [0:N_ELEMENTS-1];
   int unsigned     size_tbl [0:N_ELEMENTS-1];
   int unsigned     sets_left;

   outcome_type pending_outcomes [$];
   int       fail_count = 0;
   bit       no_idle = 1'b0;   // set to run a stretch at full rate

   disjoint_set_union_engine_core #(
      .ELEMENTS(N_ELEMENTS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_first_element   (req_first_element),
      .req_second_element  (req_second_element),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_root            (rsp_root),
      .rsp_already_joined  (rsp_already_joined),
      .rsp_root_set_size   (rsp_root_set_size),
      .rsp_component_count (rsp_component_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("** disjoint_set_union_engine_core: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------
   // Shadow model
   // ------------------------------------------------------------------
   task automatic clear_table();
      for (int i = 0; i < N_ELEMENTS; i++) begin
         parent_tbl[i] = EL_W'(i);
         size_tbl[i] = 1;
      end
      sets_left = N_ELEMENTS;
   endtask

   // Climb to the root, then point every node on the path straight at it.
   function automatic logic [EL_W-1:0] root_of(input logic [EL_W-1:0] start);
      logic [EL_W-1:0] top;
      logic [EL_W-1:0] walk;
      logic [EL_W-1:0] up;
      top = start;
      while (parent_tbl[top] != top)
         top = parent_tbl[top];
      walk = start;
      while (walk != top) begin
         up = parent_tbl[walk];
         parent_tbl[walk] = top;
         walk = up;
      end
      return top;
   endfunction

   function automatic outcome_type predict_outcome(input logic m,
                                                   input logic [EL_W-1:0] a,
                                                   input logic [EL_W-1:0] b);
      outcome_type     res;
      logic [EL_W-1:0] ra;
      logic [EL_W-1:0] rb;
      res.joined = 1'b0;
      // an index past the table is a no-op flagged by a zero size
      if (int'(a) >= N_ELEMENTS || (m == MODE_MERGE && int'(b) >= N_ELEMENTS)) begin
         res.root = a;
         res.set_size = '0;
         res.count = SZ_OUT_W'(sets_left);
         return res;
      end
      if (m == MODE_FIND) begin
         res.root = root_of(a);
      end else begin
         ra = root_of(a);
         rb = root_of(b);
         if (ra == rb) begin
            res.joined = 1'b1;
            res.root = ra;
         end else if (size_tbl[ra] < size_tbl[rb]) begin
            parent_tbl[ra] = rb;
            size_tbl[rb] += size_tbl[ra];
            res.root = rb;
            sets_left--;
         end else begin
            // equal sizes: the first element's root stays on top
            parent_tbl[rb] = ra;
            size_tbl[ra] += size_tbl[rb];
            res.root = ra;
            sets_left--;
         end
      end
      res.set_size = SZ_OUT_W'(size_tbl[res.root]);
      res.count = SZ_OUT_W'(sets_left);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Request side. Entered and left at a falling edge; valid stays high
   // on return so back-to-back transfers need no extra assignment.
   // ------------------------------------------------------------------
   task automatic send_request(input logic m, input logic [EL_W-1:0] a,
                               input logic [EL_W-1:0] b);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_first_element <= a;
      req_second_element <= b;
      do
         @(posedge clock);
      while (!req_ready);
      pending_outcomes = {pending_outcomes, predict_outcome(m, a, b)};
      @(negedge clock);
   endtask

   // Response side: random back-pressure, sampled at the rising edge.
   always @(negedge clock)
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response transfer with nothing pending: root %0d", rsp_root);
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_root !== want.root) begin
               $error("root: expected %0d, actual %0d", want.root, rsp_root);
               fail_count++;
            end
            if (rsp_already_joined !== want.joined) begin
               $error("already_joined: expected %0d, actual %0d", want.joined,
                      rsp_already_joined);
               fail_count++;
            end
            if (rsp_root_set_size !== want.set_size) begin
               $error("root_set_size: expected %0d, actual %0d", want.set_size,
                      rsp_root_set_size);
               fail_count++;
            end
            if (rsp_component_count !== want.count) begin
               $error("component_count: expected %0d, actual %0d", want.count,
                      rsp_component_count);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-picked requests: index extremes, ties, smaller-first merges,
   // repeat merges, self merge, compression of a two-level path.
   task automatic test_directed();
      send_request(MODE_FIND, 10'd0, EL_W'($urandom));
      send_request(MODE_FIND, 10'd1023, 10'd1023);
      send_request(MODE_MERGE, 10'd0, 10'd1023);      // tie, 0 stays root
      send_request(MODE_MERGE, 10'd1023, 10'd0);      // already joined
      send_request(MODE_MERGE, 10'd7, 10'd7);         // element with itself
      send_request(MODE_MERGE, 10'd1, 10'd2);
      send_request(MODE_MERGE, 10'd3, 10'd1);         // smaller set given first
      send_request(MODE_MERGE, 10'd1, 10'd0);         // 1023 now two levels down
      send_request(MODE_FIND, 10'd1023, 10'd0);       // compresses the path
      send_request(MODE_FIND, 10'd1023, 10'd1023);
      send_request(MODE_MERGE, 10'd512, 10'd511);
      send_request(MODE_MERGE, 10'd682, 10'd341);
      send_request(MODE_FIND, 10'd341, 10'd1023);     // second field ignored
      send_request(MODE_MERGE, 10'd511, 10'd682);     // tie of two pairs
      send_request(MODE_MERGE, 10'd341, 10'd2);       // 4 under 5
      send_request(MODE_FIND, 10'd682, 10'd0);
   endtask

   // Doubling merges over one block give the deepest trees union by size
   // allows; members are picked at random, so a merge may walk a path.
   task automatic test_deep_trees(input int base, input int span);
      logic [EL_W-1:0] a;
      logic [EL_W-1:0] b;
      int              lo;
      for (int s = 1; s < span; s *= 2) begin
         for (int i = 0; i < span / (2 * s); i++) begin
            lo = base + i * 2 * s;
            a = EL_W'(lo + $urandom_range(0, s - 1));
            b = EL_W'(lo + s + $urandom_range(0, s - 1));
            if ($urandom_range(0, 1))
               send_request(MODE_MERGE, a, b);
            else
               send_request(MODE_MERGE, b, a);
         end
      end
      repeat (span / 4)
         send_request(MODE_FIND, EL_W'(base + $urandom_range(0, span - 1)),
                      EL_W'($urandom));
   endtask

   // Bursts over windows of varied size: narrow windows build deep sets
   // and repeat merges, the full window spreads over every index bit.
   task automatic test_random_windows(input int bursts);
      int pool;
      int base;
      logic m;
      for (int k = 0; k < bursts; k++) begin
         case ($urandom_range(0, 4))
            0: pool = 8;
            1: pool = 16;
            2: pool = 64;
            3: pool = 256;
            default: pool = N_ELEMENTS;
         endcase
         base = $urandom_range(0, N_ELEMENTS - pool);
         repeat (50) begin
            m = ($urandom_range(0, 99) < 60) ? MODE_MERGE : MODE_FIND;
            send_request(m, EL_W'(base + $urandom_range(0, pool - 1)),
                         (m == MODE_MERGE) ? EL_W'(base + $urandom_range(0, pool - 1))
                                           : EL_W'($urandom));
         end
      end
   endtask

   initial begin
      clear_table();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      no_idle = 1'b1;
      test_deep_trees(256, 64);
      no_idle = 1'b0;
      test_deep_trees(768, 32);
      test_random_windows(16);

      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("** disjoint_set_union_engine_core: PASSED **");
      else
         $display("** disjoint_set_union_engine_core: FAILED **");
      $finish;
   end

endmodule
